/* rtl/tafh_pkg.sv */
// shared constants and helpers for the thermal alarm and fan hysteresis monitor
`default_nettype none

package tafh_pkg;

    // threshold field width and packed register widths
    localparam int THR_BITS       = 18;
    localparam int THR3_WIDTH     = 3 * THR_BITS;
    localparam int THR2_WIDTH     = 2 * THR_BITS;
    localparam int LIMIT_WIDTH    = 8;
    localparam int CFG_ADDR_WIDTH = 4;
    localparam int CFG_DATA_WIDTH = THR3_WIDTH;

    // reading conversion
    localparam int MDEG_PER_DEG = 1000;
    localparam int HALF_MDEG    = 500;

    // stream payload widths
    localparam int IN_DATA_WIDTH  = 16;
    localparam int OUT_DATA_WIDTH = 72;

    typedef logic signed [THR_BITS-1:0] thr_t;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_ALARM_RISE = 4'd0,
        CFG_ALARM_FALL = 4'd1,
        CFG_LOW        = 4'd2,
        CFG_FAN_RISE   = 4'd3,
        CFG_FAN_FALL   = 4'd4,
        CFG_TEST_EN    = 4'd5,
        CFG_TEST_TEMP  = 4'd6,
        CFG_RETRY      = 4'd7
    } cfg_addr_t;

    // pick threshold k from a packed word, first field in the lowest bits
    function automatic thr_t thr_field(input logic [THR3_WIDTH-1:0] packed_thr,
                                       input logic [1:0] k);
        logic [THR3_WIDTH-1:0] shifted;
        shifted = packed_thr >> (k * THR_BITS);
        return thr_t'(shifted[THR_BITS-1:0]);
    endfunction

endpackage

`default_nettype wire

/* rtl/thermal_alarm_fan_hysteresis.sv */
// thermal alarm and fan hysteresis monitor, top level
//
// one sensor poll comes in on the s_ stream: s_tuser carries the read-ok flag,
// s_tdata the signed whole degrees and the half-degree bit. each poll gives
// exactly one result on the m_ stream: alarm level, fan level, current,
// lowest and highest temperature in millidegrees and the failed-read count.
// thresholds, test override and retry limit are written on the cfg_ channel
// (index, 54-bit data); the user writes only while no poll is in flight, not
// enforced by the block. cfg_ready is always high, unknown indexes are dropped.
// a poll sits in the input register, then the alarm and fan chains run in a
// single combinational pass and the result register and tracking state load
// together, so m_tvalid rises after both the input and the result register.
// throughput is one poll per cycle while m_tready is high; the next poll sees
// the state left by the previous one since state and result load on the same edge.
// when m_tready is low the result holds and one more poll waits in the input
// register; s_tready drops only when both are full.
// reset clears the registers to their defaults (retry limit 3), alarm and
// fan to normal, lowest to the largest and highest to the most negative
// temperature, and empties both pipeline registers.
`default_nettype none

module thermal_alarm_fan_hysteresis #(
    parameter int TEMP_WIDTH  = 18,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // config write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tafh_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  wire logic [tafh_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // poll input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [7:0] whole_degrees, [8] half_degree, [15:9] zero
    input  wire logic [tafh_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
    // [0] read_ok
    input  wire logic                                 s_tuser,
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [2:0] alarm_level, [4:3] fan_level, [22:5] temp_mdeg, [40:23] lowest_mdeg,
    // [58:41] highest_mdeg, [66:59] fail_count, [71:67] zero
    output logic [tafh_pkg::OUT_DATA_WIDTH-1:0]       m_tdata
);

    import tafh_pkg::*;

    typedef enum logic [2:0] {
        A_NORMAL  = 3'd0,
        A_MIN     = 3'd1,
        A_LOWCRIT = 3'd2,
        A_MAX     = 3'd3,
        A_CRIT    = 3'd4,
        A_EMERG   = 3'd5,
        A_FAILED  = 3'd6
    } alarm_t;

    typedef enum logic [1:0] {
        F_NORMAL = 2'd0,
        F_MEDIUM = 2'd1,
        F_FAST   = 2'd2,
        F_MAX    = 2'd3
    } fan_t;

    typedef logic signed [TEMP_WIDTH-1:0] temp_t;

    localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
    localparam temp_t LOW_INIT  = {1'b0, {(TEMP_WIDTH-1){1'b1}}};
    localparam temp_t HIGH_INIT = {1'b1, {(TEMP_WIDTH-1){1'b0}}};
    localparam temp_t MDEG_K    = TEMP_WIDTH'(MDEG_PER_DEG);
    localparam temp_t HALF_K    = TEMP_WIDTH'(HALF_MDEG);

    // configuration registers
    logic [THR3_WIDTH-1:0]  alarm_rise_reg;
    logic [THR3_WIDTH-1:0]  alarm_fall_reg;
    logic [THR2_WIDTH-1:0]  low_levels_reg;
    logic [THR3_WIDTH-1:0]  fan_rise_reg;
    logic [THR3_WIDTH-1:0]  fan_fall_reg;
    logic                   test_en_reg;
    thr_t                   override_temp_reg;
    logic [LIMIT_WIDTH-1:0] retry_limit_reg;

    // input register
    logic       in_valid_reg;
    logic       in_ok_reg;
    logic [7:0] in_deg_reg;
    logic       in_half_reg;

    // tracking state
    temp_t                  cur_temp_reg;
    temp_t                  lowest_reg;
    temp_t                  highest_reg;
    alarm_t                 alarm_reg;
    fan_t                   fan_reg;
    logic [COUNT_WIDTH-1:0] fail_cnt_reg;

    // result register
    logic                      out_valid_reg;
    logic [OUT_DATA_WIDTH-1:0] out_data_reg;

    logic advance;

    temp_t                  reading_next;
    temp_t                  lowest_next;
    temp_t                  highest_next;
    alarm_t                 alarm_next;
    fan_t                   fan_next;
    logic [COUNT_WIDTH-1:0] fail_cnt_next;
    logic [OUT_DATA_WIDTH-1:0] out_data_next;

    temp_t                  deg_ext;
    temp_t                  conv_temp;
    logic [CMP_WIDTH-1:0]   fail_ext;
    logic [CMP_WIDTH-1:0]   limit_ext;
    logic [CMP_WIDTH-1:0]   fail_out_ext;

    function automatic temp_t thr_ext(input logic [THR3_WIDTH-1:0] packed_thr,
                                      input logic [1:0] k);
        return TEMP_WIDTH'(thr_field(packed_thr, k));
    endfunction

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_rise_reg    <= '0;
            alarm_fall_reg    <= '0;
            low_levels_reg    <= '0;
            fan_rise_reg      <= '0;
            fan_fall_reg      <= '0;
            test_en_reg       <= 1'b0;
            override_temp_reg <= '0;
            retry_limit_reg   <= LIMIT_WIDTH'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_ALARM_RISE: alarm_rise_reg    <= cfg_data;
                CFG_ALARM_FALL: alarm_fall_reg    <= cfg_data;
                CFG_LOW:        low_levels_reg    <= cfg_data[THR2_WIDTH-1:0];
                CFG_FAN_RISE:   fan_rise_reg      <= cfg_data;
                CFG_FAN_FALL:   fan_fall_reg      <= cfg_data;
                CFG_TEST_EN:    test_en_reg       <= cfg_data[0];
                CFG_TEST_TEMP:  override_temp_reg <= thr_t'(cfg_data[THR_BITS-1:0]);
                CFG_RETRY:      retry_limit_reg   <= cfg_data[LIMIT_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        deg_ext   = TEMP_WIDTH'($signed(in_deg_reg));
        conv_temp = deg_ext * MDEG_K + (in_half_reg ? HALF_K : '0);
        fail_ext  = CMP_WIDTH'(fail_cnt_reg);
        limit_ext = CMP_WIDTH'(retry_limit_reg);

        reading_next  = cur_temp_reg;
        alarm_next    = alarm_reg;
        fail_cnt_next = fail_cnt_reg;

        if (test_en_reg)
        begin
            alarm_next   = A_NORMAL;
            reading_next = TEMP_WIDTH'(override_temp_reg);
        end
        else if (!in_ok_reg)
        begin
            if (fail_ext > limit_ext)
                alarm_next = A_FAILED;
            if (fail_cnt_reg != '1)
                fail_cnt_next = fail_cnt_reg + 1'b1;
        end
        else
        begin
            fail_cnt_next = '0;
            if (alarm_reg == A_FAILED)
                alarm_next = A_NORMAL;
            reading_next = conv_temp;
        end

        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        fan_next     = fan_reg;

        if (alarm_next != A_FAILED)
        begin
            if (lowest_reg > reading_next)
                lowest_next = reading_next;
            if (highest_reg < reading_next)
                highest_next = reading_next;

            // falling side first, then rising, same order as a chain of checks
            if (alarm_next == A_EMERG && reading_next <= thr_ext(alarm_fall_reg, 2'd2))
                alarm_next = A_CRIT;
            if (alarm_next == A_CRIT && reading_next <= thr_ext(alarm_fall_reg, 2'd1))
                alarm_next = A_MAX;
            if (alarm_next == A_MAX && reading_next <= thr_ext(alarm_fall_reg, 2'd0))
                alarm_next = A_NORMAL;
            // low critical recovers to below min first
            if (alarm_next == A_LOWCRIT
                && reading_next > thr_ext(THR3_WIDTH'(low_levels_reg), 2'd1))
                alarm_next = A_MIN;
            if (alarm_next == A_MIN
                && reading_next > thr_ext(THR3_WIDTH'(low_levels_reg), 2'd0))
                alarm_next = A_NORMAL;

            if (alarm_next == A_NORMAL && reading_next >= thr_ext(alarm_rise_reg, 2'd0))
                alarm_next = A_MAX;
            if (alarm_next == A_MAX && reading_next >= thr_ext(alarm_rise_reg, 2'd1))
                alarm_next = A_CRIT;
            if (alarm_next == A_CRIT && reading_next >= thr_ext(alarm_rise_reg, 2'd2))
                alarm_next = A_EMERG;
            if (alarm_next == A_NORMAL
                && reading_next <= thr_ext(THR3_WIDTH'(low_levels_reg), 2'd0))
                alarm_next = A_MIN;
            if (alarm_next == A_MIN
                && reading_next <= thr_ext(THR3_WIDTH'(low_levels_reg), 2'd1))
                alarm_next = A_LOWCRIT;

            if (fan_next == F_NORMAL && reading_next >= thr_ext(fan_rise_reg, 2'd0))
                fan_next = F_MEDIUM;
            if (fan_next == F_MEDIUM && reading_next >= thr_ext(fan_rise_reg, 2'd1))
                fan_next = F_FAST;
            if (fan_next == F_FAST && reading_next >= thr_ext(fan_rise_reg, 2'd2))
                fan_next = F_MAX;
            if (fan_next == F_MAX && reading_next <= thr_ext(fan_fall_reg, 2'd2))
                fan_next = F_FAST;
            if (fan_next == F_FAST && reading_next <= thr_ext(fan_fall_reg, 2'd1))
                fan_next = F_MEDIUM;
            if (fan_next == F_MEDIUM && reading_next <= thr_ext(fan_fall_reg, 2'd0))
                fan_next = F_NORMAL;
        end

        fail_out_ext  = CMP_WIDTH'(fail_cnt_next);
        out_data_next = {5'b0,
                         fail_out_ext[7:0],
                         highest_next[THR_BITS-1:0],
                         lowest_next[THR_BITS-1:0],
                         reading_next[THR_BITS-1:0],
                         fan_next,
                         alarm_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_temp_reg  <= '0;
            lowest_reg    <= LOW_INIT;
            highest_reg   <= HIGH_INIT;
            alarm_reg     <= A_NORMAL;
            fan_reg       <= F_NORMAL;
            fail_cnt_reg  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cur_temp_reg  <= reading_next;
                lowest_reg    <= lowest_next;
                highest_reg   <= highest_next;
                alarm_reg     <= alarm_next;
                fan_reg       <= fan_next;
                fail_cnt_reg  <= fail_cnt_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ok_reg   <= s_tuser;
            in_deg_reg  <= s_tdata[7:0];
            in_half_reg <= s_tdata[8];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

    // a failed alarm only comes from counted failed reads
    a_failed_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_reg == A_FAILED |-> fail_cnt_reg != '0)
        else $error("failed alarm with zero fail count");

    // min/max tracking stays ordered once any reading went in
    a_track_order: assert property (@(posedge clk) disable iff (!rst_n)
        (lowest_reg <= highest_reg) || (lowest_reg == LOW_INIT && highest_reg == HIGH_INIT))
        else $error("lowest above highest");

    // a request moved out of the input register shows up as a result next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result missing after advance");

    // input side stalls only with both registers full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room left");

endmodule

`default_nettype wire
